[rtl/core/tqsa_pkg.sv]
`timescale 1ns / 1ps

package tqsa_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int PTR_W  = $clog2(DEPTH + 1) + 1;
	localparam int CMD_W  = 3;
	localparam int WORD_W = 32;
	localparam int STAT_W = 2;

	typedef logic signed [PTR_W-1:0] ptr_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_A = 3'd0,
		CMD_PUSH_B = 3'd1,
		CMD_POP_A  = 3'd2,
		CMD_POP_B  = 3'd3,
		CMD_SHOW_A = 3'd4,
		CMD_SHOW_B = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_OVER  = 2'd1,
		ST_UNDER = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic walk_load;
		logic rd_en;
		logic emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		cmd_t cmd;
		logic empty;
		logic out_free;
		logic walk_last;
	} sts_t;

endpackage

[rtl/core/two_queues_shared_array_unit.sv]
`timescale 1ns / 1ps
// channel | direction | tdata          | tuser        | tlast
// s_      | in        | value [31:0]   | cmd [2:0]    | -
// m_      | out       | data [31:0]    | status [1:0] | last of command
//
// one command at a time; push, failed pop and empty show finish in the exec state
// pop and show load the walk index, then do a registered store read, then a beat
// show repeats read and beat up to the rear; unused command codes give no beat
// reset: queue a pointers at -1, queue b pointers at DEPTH, no beat pending
// a stalled output beat holds the controller; input is taken only when idle

module two_queues_shared_array_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tqsa_pkg::WORD_W-1:0] s_tdata,  // value
	input  logic [tqsa_pkg::CMD_W-1:0]  s_tuser,  // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tqsa_pkg::WORD_W-1:0] m_tdata,  // data
	output logic [tqsa_pkg::STAT_W-1:0] m_tuser,  // status
	output logic                        m_tlast
);
	import tqsa_pkg::*;

	ctl_t ctl;
	sts_t sts;

	tqsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	tqsa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (s_tuser),
		.in_value   (s_tdata),
		.ctl        (ctl),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

`ifndef ASSERT_OFF
	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ctl))
		else $error("controller commands overlap");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while a command is in flight");

	a_fail_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0 && m_tlast))
		else $error("failed status beat carries data or is not last");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(ctl.exec || ctl.emit))
		else $error("output beat overwritten while stalled");
`endif

endmodule

[rtl/core/tqsa_dp.sv]
`timescale 1ns / 1ps

module tqsa_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [tqsa_pkg::CMD_W-1:0]    in_cmd,
	input  logic [tqsa_pkg::WORD_W-1:0]   in_value,
	input  tqsa_pkg::ctl_t                ctl,
	output tqsa_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tqsa_pkg::STAT_W-1:0]   out_status,
	output logic [tqsa_pkg::WORD_W-1:0]   out_data,
	output logic                          out_last
);
	import tqsa_pkg::*;

	localparam ptr_t PTR_NEG1 = '1;
	localparam ptr_t PTR_TOP  = PTR_W'(DEPTH);
	localparam ptr_t PTR_TOPM = PTR_W'(DEPTH - 1);
	localparam ptr_t PTR_ONE  = PTR_W'(1);

	function automatic logic in_range(input ptr_t p);
		in_range = (p >= ptr_t'(0)) && (p < PTR_TOP);
	endfunction

	logic [WORD_W-1:0] mem [DEPTH];

	cmd_t              cmd_q;
	logic [WORD_W-1:0] value_q;
	ptr_t              front_a_q, rear_a_q, front_b_q, rear_b_q;
	ptr_t              walk_q;
	logic [WORD_W-1:0] rdata_q;
	logic              out_valid_q;
	stat_t             out_status_q;
	logic [WORD_W-1:0] out_data_q;
	logic              out_last_q;

	logic qsel_b, empty_a, empty_b, full, is_push, is_pop;
	logic restart_a, restart_b, out_free, walk_last;
	ptr_t nxt_rear_a, nxt_rear_b, wr_ptr;

	assign qsel_b    = cmd_q[0];
	assign empty_a   = (front_a_q == PTR_NEG1) || (front_a_q > rear_a_q);
	assign empty_b   = (front_b_q == PTR_TOP) || (front_b_q < rear_b_q);
	assign full      = (rear_a_q == rear_b_q - PTR_ONE);
	assign is_push   = (cmd_q == CMD_PUSH_A) || (cmd_q == CMD_PUSH_B);
	assign is_pop    = (cmd_q == CMD_POP_A) || (cmd_q == CMD_POP_B);
	assign restart_a = (rear_a_q == PTR_NEG1) || (front_a_q == PTR_NEG1);
	assign restart_b = (rear_b_q == PTR_TOP) || (front_b_q == PTR_TOP);
	assign nxt_rear_a = restart_a ? ptr_t'(0) : rear_a_q + PTR_ONE;
	assign nxt_rear_b = restart_b ? PTR_TOPM : rear_b_q - PTR_ONE;
	assign wr_ptr    = qsel_b ? nxt_rear_b : nxt_rear_a;
	assign walk_last = (walk_q == (qsel_b ? rear_b_q : rear_a_q));
	assign out_free  = !out_valid_q || out_ready;

	assign sts.cmd       = cmd_q;
	assign sts.empty     = qsel_b ? empty_b : empty_a;
	assign sts.out_free  = out_free;
	assign sts.walk_last = walk_last;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= cmd_t'(in_cmd);
			value_q <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_a_q <= PTR_NEG1;
			rear_a_q  <= PTR_NEG1;
			front_b_q <= PTR_TOP;
			rear_b_q  <= PTR_TOP;
		end else if (ctl.exec) begin
			unique case (cmd_q)
				CMD_PUSH_A: begin
					if (!full) begin
						rear_a_q <= nxt_rear_a;
						if (restart_a) front_a_q <= ptr_t'(0);
					end
				end
				CMD_PUSH_B: begin
					if (!full) begin
						rear_b_q <= nxt_rear_b;
						if (restart_b) front_b_q <= PTR_TOPM;
					end
				end
				// exec on a pop only happens for an empty queue
				CMD_POP_A: begin
					front_a_q <= PTR_NEG1;
					rear_a_q  <= PTR_NEG1;
				end
				CMD_POP_B: begin
					front_b_q <= PTR_TOP;
					rear_b_q  <= PTR_TOP;
				end
				default: ;
			endcase
		end else if (ctl.emit) begin
			if (cmd_q == CMD_POP_A) front_a_q <= front_a_q + PTR_ONE;
			if (cmd_q == CMD_POP_B) front_b_q <= front_b_q - PTR_ONE;
		end
	end

	// walk index: pop uses it for the front, show steps it toward the rear
	always_ff @(posedge clk) begin
		if (ctl.walk_load) begin
			walk_q <= qsel_b ? front_b_q : front_a_q;
		end else if (ctl.emit) begin
			walk_q <= qsel_b ? walk_q - PTR_ONE : walk_q + PTR_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && is_push && !full && in_range(wr_ptr)) begin
			mem[wr_ptr[IDX_W-1:0]] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= in_range(walk_q) ? mem[walk_q[IDX_W-1:0]] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec || ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			out_status_q <= is_push ? (full ? ST_OVER : ST_OK) : ST_UNDER;
			out_data_q   <= '0;
			out_last_q   <= 1'b1;
		end else if (ctl.emit) begin
			out_status_q <= ST_OK;
			out_data_q   <= rdata_q;
			out_last_q   <= is_pop || walk_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_last   = out_last_q;

endmodule

[rtl/core/tqsa_ctrl.sv]
`timescale 1ns / 1ps

module tqsa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tqsa_pkg::sts_t sts,
	output tqsa_pkg::ctl_t ctl
);
	import tqsa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				unique case (sts.cmd)
					CMD_PUSH_A, CMD_PUSH_B: begin
						if (sts.out_free) begin
							ctl.exec = 1'b1;
							state_d  = S_IDLE;
						end
					end
					CMD_POP_A, CMD_POP_B, CMD_SHOW_A, CMD_SHOW_B: begin
						if (!sts.empty) begin
							ctl.walk_load = 1'b1;
							state_d       = S_READ;
						end else if (sts.out_free) begin
							ctl.exec = 1'b1;
							state_d  = S_IDLE;
						end
					end
					// unused command codes give no beat
					default: state_d = S_IDLE;
				endcase
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (sts.cmd == CMD_POP_A || sts.cmd == CMD_POP_B || sts.walk_last) begin
						state_d = S_IDLE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
